// File: hdl/grid_bfs_move_distance_unit_defines.svh
// Assertion macros used by the checker module of the move distance unit.
`ifndef GRID_BFS_MOVE_DISTANCE_UNIT_DEFINES_SVH
`define GRID_BFS_MOVE_DISTANCE_UNIT_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define GBMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gbmd assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define GBMD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gbmd assertion failed");

`endif

// File: hdl/gbmd_pkg.sv
// Shared types, constants and move table of the grid move distance unit.
package gbmd_pkg;

    localparam int GBMD_MAX_SIDE = 256;
    localparam logic [8:0] GBMD_BOARD_RESET = 9'd8;
    localparam int GBMD_NUM_MOVES = 6;

    typedef logic [2:0] t_move_idx;

    localparam t_move_idx GBMD_LAST_MOVE = t_move_idx'(GBMD_NUM_MOVES - 1);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load_query;
        logic      clear_step;
        logic      seed;
        logic      fetch;
        logic      nbr_issue;
        t_move_idx nbr_sel;
        logic      set_hit;
        logic      set_miss;
        logic      load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic off_board;
        logic clear_last;
        logic queue_empty;
        logic hit;
    } t_dp_stat;

    function automatic logic signed [2:0] move_dr(input t_move_idx idx);
        logic signed [2:0] d;
        case (idx)
            3'd0, 3'd1: d = -3'sd2;
            3'd2, 3'd3: d = 3'sd0;
            3'd4, 3'd5: d = 3'sd2;
            default:    d = 3'sd0;
        endcase
        return d;
    endfunction

    function automatic logic signed [2:0] move_dc(input t_move_idx idx);
        logic signed [2:0] d;
        case (idx)
            3'd0, 3'd4: d = -3'sd1;
            3'd1, 3'd5: d = 3'sd1;
            3'd2:       d = -3'sd2;
            3'd3:       d = 3'sd2;
            default:    d = 3'sd0;
        endcase
        return d;
    endfunction

endpackage

// File: hdl/grid_bfs_move_distance_unit.sv
// Flow, from the accepted query to a valid result: a query with a cell off the board is
// answered as unreachable without a search; otherwise a clearing pass over all
// 2**(2*clog2(MAX_SIDE)) visited marks (65536 by default) precedes the search of the queue.
// One query is worked at a time and the next is taken once the result is loaded; the clearing
// pass and the six-step neighbor sequencer set the rate, and a held result stalls the loading of a new one.
// Reset is synchronous and active low; it sets board_size to 8 and empties the output.
module grid_bfs_move_distance_unit
    import gbmd_pkg::*;
#(
    parameter int MAX_SIDE = GBMD_MAX_SIDE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_start_row,
    input  logic [7:0]  i_start_col,
    input  logic [7:0]  i_target_row,
    input  logic [7:0]  i_target_col,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_move_count,
    output logic        o_reachable,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [8:0]  i_board_size
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    gbmd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    gbmd_datapath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_board_size),
        .i_start_row  (i_start_row),
        .i_start_col  (i_start_col),
        .i_target_row (i_target_row),
        .i_target_col (i_target_col),
        .o_move_count (o_move_count),
        .o_reachable  (o_reachable)
    );

endmodule

// File: hdl/gbmd_ctrl.sv
// Sequencer that steps the datapath through clear, seed and search of one query.
module gbmd_ctrl
    import gbmd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_CLEAR,
        S_SEED,
        S_FETCH,
        S_TEST,
        S_NBR,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state    r_state, n_state;
    t_move_idx r_k, n_k;
    logic      r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.nbr_sel = r_k;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_query = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.off_board) begin
                    o_cmd.set_miss = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_SEED;
                end
            end
            S_SEED: begin
                o_cmd.seed = 1'b1;
                n_state = S_FETCH;
            end
            S_FETCH: begin
                if (i_stat.queue_empty) begin
                    o_cmd.set_miss = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.fetch = 1'b1;
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (i_stat.hit) begin
                    o_cmd.set_hit = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_k = '0;
                    n_state = S_NBR;
                end
            end
            S_NBR: begin
                o_cmd.nbr_issue = 1'b1;
                if (r_k == GBMD_LAST_MOVE) begin
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            S_DRAIN: begin
                // The last neighbor is checked and pushed in this cycle.
                n_state = S_FETCH;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: hdl/gbmd_datapath.sv
// Board register, visited map, search queue and level counter of the search.
module gbmd_datapath
    import gbmd_pkg::*;
#(
    parameter int MAX_SIDE = GBMD_MAX_SIDE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_data,
    input  logic [7:0]  i_start_row,
    input  logic [7:0]  i_start_col,
    input  logic [7:0]  i_target_row,
    input  logic [7:0]  i_target_col,
    output logic [15:0] o_move_count,
    output logic        o_reachable
);

    localparam int CW     = $clog2(MAX_SIDE);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int NW     = CW + 2;
    localparam int VA_W   = 2 * CW;
    localparam int VDEPTH = 1 << VA_W;
    localparam int QDEPTH = MAX_SIDE * MAX_SIDE;
    localparam int QA_W   = $clog2(QDEPTH);
    localparam int QC_W   = $clog2(QDEPTH + 1);

    logic [8:0]      r_board_size;
    logic [7:0]      r_sr, r_sc, r_tr, r_tc;
    logic [VA_W-1:0] r_clr;
    logic [QC_W-1:0] r_head, r_tail, r_level_end;
    logic [15:0]     r_dist;
    logic [15:0]     r_res_count, r_move_count;
    logic            r_res_reach, r_reachable;
    logic            r_p_valid, r_p_inb;
    logic [VA_W-1:0] r_p_cell;

    // Visited marks, one per cell, addressed by {row, column}.
    logic            r_visited [VDEPTH];
    logic            r_vis_rdata;
    // Search queue of {row, column} cells.
    logic [VA_W-1:0] r_queue [QDEPTH];
    logic [VA_W-1:0] r_q_rdata;

    logic [SIDE_W-1:0]   side;
    logic [VA_W-1:0]     start_cell, target_cell, nbr_cell;
    logic [CW-1:0]       cur_row, cur_col;
    logic signed [NW-1:0] nr, nc;
    logic                nbr_inb;
    logic                push_ok, q_push;
    logic                vis_we, vis_wdata;
    logic [VA_W-1:0]     vis_waddr;
    logic                q_we;
    logic [QA_W-1:0]     q_waddr;
    logic [VA_W-1:0]     q_wdata;

    // A board wider than the storage is clamped to the storage size.
    assign side = (32'(r_board_size) > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                      : SIDE_W'(r_board_size);

    assign start_cell  = {CW'(r_sr), CW'(r_sc)};
    assign target_cell = {CW'(r_tr), CW'(r_tc)};
    assign cur_row     = r_q_rdata[VA_W-1:CW];
    assign cur_col     = r_q_rdata[CW-1:0];

    assign nr = $signed({2'b00, cur_row}) + NW'(move_dr(i_cmd.nbr_sel));
    assign nc = $signed({2'b00, cur_col}) + NW'(move_dc(i_cmd.nbr_sel));
    assign nbr_inb = !nr[NW-1] && !nc[NW-1]
                  && ($unsigned(nr) < NW'(side)) && ($unsigned(nc) < NW'(side));
    assign nbr_cell = {nr[CW-1:0], nc[CW-1:0]};

    // The six neighbors of one cell are distinct, so a pending write never
    // collides with the read issued in the same cycle.
    assign push_ok = r_p_valid && r_p_inb && !r_vis_rdata;
    assign q_push  = push_ok && (r_tail != QC_W'(QDEPTH));

    assign vis_we    = i_cmd.clear_step || i_cmd.seed || push_ok;
    assign vis_wdata = !i_cmd.clear_step;
    assign vis_waddr = i_cmd.clear_step ? r_clr : (i_cmd.seed ? start_cell : r_p_cell);

    assign q_we    = i_cmd.seed || q_push;
    assign q_waddr = i_cmd.seed ? '0 : r_tail[QA_W-1:0];
    assign q_wdata = i_cmd.seed ? start_cell : r_p_cell;

    always_comb begin
        o_stat.off_board   = (32'(r_sr) >= 32'(side)) || (32'(r_sc) >= 32'(side))
                          || (32'(r_tr) >= 32'(side)) || (32'(r_tc) >= 32'(side));
        o_stat.clear_last  = (r_clr == '1);
        o_stat.queue_empty = (r_head == r_tail);
        o_stat.hit         = (r_q_rdata == target_cell);
    end

    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            r_visited[vis_waddr] <= vis_wdata;
        end
        r_vis_rdata <= r_visited[nbr_cell];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_queue[q_waddr] <= q_wdata;
        end
        if (i_cmd.fetch) begin
            r_q_rdata <= r_queue[r_head[QA_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_size <= GBMD_BOARD_RESET;
            r_clr        <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_level_end  <= '0;
            r_dist       <= '0;
            r_p_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_board_size <= i_cfg_data;
            end
            if (i_cmd.load_query) begin
                r_clr <= '0;
            end else if (i_cmd.clear_step) begin
                r_clr <= r_clr + 1'b1;
            end
            r_p_valid <= i_cmd.nbr_issue;
            if (i_cmd.seed) begin
                r_head      <= '0;
                r_tail      <= QC_W'(1);
                r_level_end <= QC_W'(1);
                r_dist      <= '0;
            end else begin
                if (i_cmd.fetch) begin
                    r_head <= r_head + 1'b1;
                    // Reaching the end of a level starts the next distance.
                    if (r_head == r_level_end) begin
                        r_dist      <= r_dist + 16'd1;
                        r_level_end <= r_tail;
                    end
                end
                if (q_push) begin
                    r_tail <= r_tail + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_sr <= i_start_row;
            r_sc <= i_start_col;
            r_tr <= i_target_row;
            r_tc <= i_target_col;
        end
        r_p_inb  <= nbr_inb;
        r_p_cell <= nbr_cell;
        if (i_cmd.set_hit) begin
            r_res_count <= r_dist;
            r_res_reach <= 1'b1;
        end else if (i_cmd.set_miss) begin
            r_res_count <= '0;
            r_res_reach <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_move_count <= r_res_count;
            r_reachable  <= r_res_reach;
        end
    end

    assign o_move_count = r_move_count;
    assign o_reachable  = r_reachable;

endmodule

// File: hdl/gbmd_checker.sv
// Port-level checks of the move distance unit and their binding to the top level.
`include "grid_bfs_move_distance_unit_defines.svh"

module gbmd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_move_count,
    input logic        o_reachable
);

    `GBMD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `GBMD_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_move_count) && $stable(o_reachable))
    // An unreachable answer always carries a zero move count.
    `GBMD_ASSERT_SAME(a_miss_zero, i_clk, i_rst_n, o_out_valid && !o_reachable, o_move_count == 16'd0)
    // Only one item is in the search at a time.
    `GBMD_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule

bind grid_bfs_move_distance_unit gbmd_checker u_gbmd_checker (.*);
